/* hw/rtl/imucf_pkg.sv */
// ----------------------------------------------------------------------------
// imucf_pkg - shared types and constants of the tilt filter
// State codes, field widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package imucf_pkg;

  localparam int RawW    = 16;
  localparam int AccW    = 19;
  localparam int RateW   = 20;
  localparam int AngW    = 25;
  localparam int InW     = 7 * RawW;
  localparam int OutW    = 168;
  localparam int CordW   = 33;
  localparam int ZW      = 26;
  localparam int Steps   = 20;
  localparam int RootSteps = 30;
  localparam int RdivW   = 26;
  localparam int IdivW   = 42;

  localparam logic [15:0] WeightReset = 16'd64225;
  localparam logic signed [ZW-1:0] QuarterTurn = 26'sd5898240;
  localparam logic signed [28:0] AngMax = 29'sd16777215;
  localparam logic signed [28:0] AngMin = -29'sd16777216;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_ROOT_LD, ST_RUN, ST_PITCH_LD, ST_PITCH, ST_BLEND1, ST_BLEND2
  } state_t;

  function automatic logic [21:0] imucf_atan(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/imu_complementary_tilt_filter_top.sv */
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top - complementary pitch/roll filter
// Scales one six-axis sample and fuses accelerometer tilt with gyro rates.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample item: tdata = accel x,y,z, rate x,y,z, elapsed_us,
//   16 bits each from the lowest bit up. m_* carries one result item per
//   sample. cfg_we/cfg_wdata write the gyro blend weight (Q0.16).
//   From accept to the result register an item passes a 30-step square
//   root with a 20-step CORDIC (roll) beside it, then a 42-step serial
//   divide for the gyro increment with the pitch CORDIC beside it, then the
//   blend states ST_BLEND1 and ST_BLEND2. The next item is taken only once
//   the previous one has been loaded into the result register.
//   Reset clears the estimates, the primed flag, the output valid and sets
//   the weight to 0.98. The first item after reset loads the accelerometer
//   angles directly.
//   A stalled receiver holds the result register; the next item is still
//   accepted and computed, and waits until the register is taken.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_top
  import imucf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw, elapsed_us
  input  logic [InW-1:0]    s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps,
  // pitch_angle, roll_angle, one zero pad bit
  output logic [OutW-1:0]   m_tdata,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  state_t state, state_next;
  logic [5:0] cnt;
  logic [15:0] weight;
  logic primed;

  logic signed [15:0] ax, ay, az;
  logic [15:0] dt;

  logic [RdivW-1:0] rnum [3];
  logic [8:0]       rrem [3];
  logic signed [17:0] rate_v [3];

  logic [31:0] sq_y, sq_z;
  logic [59:0] rad;
  logic [33:0] rrt;
  logic [29:0] root;

  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic czero;
  logic signed [CordW-1:0] ld_x, ld_y, ld_xr, ld_yr;
  logic signed [ZW-1:0] ld_z;

  logic signed [34:0] iprod [2];
  logic [IdivW-1:0] inum [2];
  logic [19:0] irem [2];
  logic signed [22:0] inc_v [2];

  logic signed [ZW-1:0] roll_ang, pitch_ang;
  logic signed [AngW-1:0] est [2];
  logic signed [43:0] bprod [2];
  logic signed [ZW-1:0] acc_ang [2];
  logic signed [28:0] bval [2];
  logic signed [AngW-1:0] bsat [2];
  logic done, load_out;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_SQ;
      end
      ST_SQ: state_next = ST_ROOT_LD;
      ST_ROOT_LD: state_next = ST_RUN;
      ST_RUN: if (cnt == 6'(RootSteps - 1)) state_next = ST_PITCH_LD;
      ST_PITCH_LD: state_next = ST_PITCH;
      ST_PITCH: if (cnt == 6'(IdivW - 1)) state_next = ST_BLEND1;
      ST_BLEND1: state_next = ST_BLEND2;
      ST_BLEND2: begin
        done = !m_tvalid || m_tready;
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign load_out = done;

  always_ff @(posedge clk) begin
    if (rst) weight <= WeightReset;
    else if (cfg_we) weight <= cfg_wdata;
  end

  // CORDIC load with pre-rotation into the right half plane
  always_comb begin
    if (state == ST_ROOT_LD) begin
      ld_y = {{3{ay[15]}}, ay, 14'b0};
      ld_x = {{3{az[15]}}, az, 14'b0};
    end else begin
      ld_y = -{{3{ax[15]}}, ax, 14'b0};
      ld_x = {3'b0, root};
    end
    ld_xr = ld_x;
    ld_yr = ld_y;
    ld_z = '0;
    if (ld_x < 0) begin
      if (ld_y >= 0) begin
        ld_xr = ld_y;
        ld_yr = -ld_x;
        ld_z = QuarterTurn;
      end else begin
        ld_xr = -ld_y;
        ld_yr = ld_x;
        ld_z = -QuarterTurn;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rate_v[k] = $signed({1'b0, rnum[k][16:0]}) - 18'sd65536;
    end
    for (int k = 0; k < 2; k++) begin
      inc_v[k] = $signed({1'b0, inum[k][21:0]}) - 23'sd2097152;
    end
  end

  always_ff @(posedge clk) begin
    logic [9:0] rsh;
    logic [20:0] ish;
    logic [33:0] tsh;
    logic [33:0] trial;
    logic signed [15:0] g;
    logic signed [25:0] gyro;
    logic signed [26:0] diff;
    if (state == ST_IDLE && s_tvalid) begin
      ax <= s_tdata[15:0];
      ay <= s_tdata[31:16];
      az <= s_tdata[47:32];
      dt <= s_tdata[111:96];
      for (int k = 0; k < 3; k++) begin
        g = s_tdata[48 + 16 * k +: 16];
        rnum[k] <= 26'(({{2{g[15]}}, g, 9'b0}) + 27'sd17170563);
        rrem[k] <= '0;
      end
    end
    case (state)
      ST_SQ: begin
        sq_y <= 32'(ay * ay);
        sq_z <= 32'(az * az);
      end
      ST_ROOT_LD: begin
        rad <= {sq_y + sq_z, 28'b0};
        rrt <= '0;
        root <= '0;
        cnt <= '0;
        cx <= ld_xr;
        cy <= ld_yr;
        cz <= ld_z;
        czero <= (ld_x == 0) && (ld_y == 0);
      end
      ST_PITCH_LD: begin
        roll_ang <= czero ? '0 : cz;
        cnt <= '0;
        cx <= ld_xr;
        cy <= ld_yr;
        cz <= ld_z;
        czero <= (ld_x == 0) && (ld_y == 0);
      end
      default: ;
    endcase
    if (state == ST_RUN) begin
      cnt <= cnt + 6'd1;
      tsh = {rrt[31:0], rad[59:58]};
      trial = {2'b0, root, 2'b01};
      rad <= {rad[57:0], 2'b00};
      if (tsh >= trial) begin
        rrt <= tsh - trial;
        root <= {root[28:0], 1'b1};
      end else begin
        rrt <= tsh;
        root <= {root[28:0], 1'b0};
      end
      if (cnt < 6'd26) begin
        for (int k = 0; k < 3; k++) begin
          rsh = {rrem[k], rnum[k][RdivW-1]};
          if (rsh >= 10'd262) begin
            rrem[k] <= 9'(rsh - 10'd262);
            rnum[k] <= {rnum[k][RdivW-2:0], 1'b1};
          end else begin
            rrem[k] <= rsh[8:0];
            rnum[k] <= {rnum[k][RdivW-2:0], 1'b0};
          end
        end
      end
      if (cnt == 6'd27) begin
        for (int k = 0; k < 2; k++) begin
          iprod[k] <= 35'(rate_v[k] * $signed({1'b0, dt}));
        end
      end
      if (cnt == 6'd28) begin
        for (int k = 0; k < 2; k++) begin
          inum[k] <= 42'({iprod[k], 8'b0} + 43'sd2097152500000);
          irem[k] <= '0;
        end
      end
    end
    if (state == ST_PITCH) begin
      cnt <= cnt + 6'd1;
      for (int k = 0; k < 2; k++) begin
        ish = {irem[k], inum[k][IdivW-1]};
        if (ish >= 21'd1000000) begin
          irem[k] <= 20'(ish - 21'd1000000);
          inum[k] <= {inum[k][IdivW-2:0], 1'b1};
        end else begin
          irem[k] <= ish[19:0];
          inum[k] <= {inum[k][IdivW-2:0], 1'b0};
        end
      end
    end
    if ((state == ST_RUN || state == ST_PITCH) && cnt < 6'(Steps)) begin
      if (cy >= 0) begin
        cx <= cx + (cy >>> cnt[4:0]);
        cy <= cy - (cx >>> cnt[4:0]);
        cz <= cz + $signed({4'b0, imucf_atan(cnt[4:0])});
      end else begin
        cx <= cx - (cy >>> cnt[4:0]);
        cy <= cy + (cx >>> cnt[4:0]);
        cz <= cz - $signed({4'b0, imucf_atan(cnt[4:0])});
      end
    end
    if (state == ST_BLEND1) begin
      pitch_ang <= czero ? '0 : cz;
      for (int k = 0; k < 2; k++) begin
        gyro = 26'(est[k]) + 26'(inc_v[k]);
        diff = 27'(gyro) - 27'((k == 0) ? (czero ? 26'sd0 : cz) : roll_ang);
        bprod[k] <= 44'($signed({1'b0, weight}) * diff);
      end
    end
  end

  always_comb begin
    acc_ang[0] = pitch_ang;
    acc_ang[1] = roll_ang;
    for (int k = 0; k < 2; k++) begin
      if (primed) bval[k] = 29'(acc_ang[k]) + 29'((bprod[k] + 44'sd32768) >>> 16);
      else bval[k] = 29'(acc_ang[k]);
      if (bval[k] > AngMax) bsat[k] = AngMax[AngW-1:0];
      else if (bval[k] < AngMin) bsat[k] = AngMin[AngW-1:0];
      else bsat[k] = bval[k][AngW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est[0] <= '0;
      est[1] <= '0;
      primed <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        est[0] <= bsat[0];
        est[1] <= bsat[1];
        primed <= 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, bsat[1], bsat[0],
                  {{2{rate_v[2][17]}}, rate_v[2]},
                  {{2{rate_v[1][17]}}, rate_v[1]},
                  {{2{rate_v[0][17]}}, rate_v[0]},
                  {{3{az[15]}}, az}, {{3{ay[15]}}, ay}, {{3{ax[15]}}, ax}};
    end
  end

endmodule

/* hw/rtl/imucf_chk.sv */
// ----------------------------------------------------------------------------
// imucf_chk - port checker for the tilt filter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module imucf_chk
  import imucf_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            s_tvalid,
  input logic            s_tready,
  input logic            m_tvalid,
  input logic            m_tready,
  input logic [OutW-1:0] m_tdata
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result before work done");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter_top imucf_chk u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
